// ===== design/b64enc_pkg.sv =====
// Shared types, constants and the character lookup of the streaming Base64 encoder.
// Used by the front end, the job queue, the back end and the top level.
`timescale 1ns / 1ps

package b64enc_pkg;

	localparam int QueueDepth = 2;

	localparam logic [7:0] PadChar = 8'h3D;

	// One accepted byte expands into a job of one to four characters.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            last_msg;
	} job_t;

	typedef enum logic [1:0] {
		PHASE_FIRST  = 2'd0,
		PHASE_SECOND = 2'd1,
		PHASE_THIRD  = 2'd2
	} phase_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		logic [7:0] c;
		c = 8'h2F;
		if (s < 6'd26) begin
			c = 8'h41 + {2'b00, s};
		end else if (s < 6'd52) begin
			c = 8'h61 + {2'b00, s - 6'd26};
		end else if (s < 6'd62) begin
			c = 8'h30 + {2'b00, s - 6'd52};
		end else if (s == 6'd62) begin
			c = 8'h2B;
		end
		return c;
	endfunction

endpackage

// ===== design/b64enc_front.sv =====
// Front end of the encoder: takes a byte, tracks the group phase and leftover bits,
// and builds the characters that the byte produces. Depends on b64enc_pkg.
`timescale 1ns / 1ps

module b64enc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  logic               end_of_message,
	input  logic               take,
	output b64enc_pkg::job_t   job
);

	logic [3:0]         leftover_q;
	b64enc_pkg::phase_t phase_q;
	logic [3:0]         leftover_d;
	b64enc_pkg::phase_t phase_d;

	always_comb begin
		job.chars    = {4{b64enc_pkg::PadChar}};
		job.last_idx = 2'd0;
		job.last_msg = end_of_message;
		leftover_d   = 4'd0;
		phase_d      = b64enc_pkg::PHASE_FIRST;

		case (phase_q)
			b64enc_pkg::PHASE_SECOND: begin
				job.chars[0] = b64enc_pkg::sextet_char({leftover_q[1:0], data_byte[7:4]});
				leftover_d   = data_byte[3:0];
				phase_d      = b64enc_pkg::PHASE_THIRD;
			end
			b64enc_pkg::PHASE_THIRD: begin
				job.chars[0] = b64enc_pkg::sextet_char({leftover_q, data_byte[7:6]});
				job.chars[1] = b64enc_pkg::sextet_char(data_byte[5:0]);
				job.last_idx = 2'd1;
			end
			default: begin
				// The first phase, or an unused phase code, starts a fresh group and drops the kept bits.
				job.chars[0] = b64enc_pkg::sextet_char(data_byte[7:2]);
				leftover_d   = {2'b00, data_byte[1:0]};
				phase_d      = b64enc_pkg::PHASE_SECOND;
			end
		endcase

		if (end_of_message) begin
			if (phase_d == b64enc_pkg::PHASE_SECOND) begin
				job.chars[1] = b64enc_pkg::sextet_char({leftover_d[1:0], 4'b0000});
				job.last_idx = 2'd3;
			end else if (phase_d == b64enc_pkg::PHASE_THIRD) begin
				job.chars[1] = b64enc_pkg::sextet_char({leftover_d, 2'b00});
				job.last_idx = 2'd2;
			end
			leftover_d = 4'd0;
			phase_d    = b64enc_pkg::PHASE_FIRST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leftover_q <= 4'd0;
			phase_q    <= b64enc_pkg::PHASE_FIRST;
		end else if (take) begin
			leftover_q <= leftover_d;
			phase_q    <= phase_d;
		end
	end

endmodule

// ===== design/b64enc_queue.sv =====
// Short job queue between the front and back ends of the encoder.
// Depends on b64enc_pkg for the job type.
`timescale 1ns / 1ps

module b64enc_queue #(
	parameter int DEPTH = b64enc_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64enc_pkg::job_t push_job,
	output logic             not_full,
	input  logic             pop,
	output logic             not_empty,
	output b64enc_pkg::job_t head_job
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	b64enc_pkg::job_t  slots_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign not_full  = (count_q != CntW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_job  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ===== design/b64enc_back.sv =====
// Back end of the encoder: holds one job and sends its characters one per cycle while
// char_ready is high, through a registered output. Depends on b64enc_pkg for the job type.
`timescale 1ns / 1ps

module b64enc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_ready,
	input  b64enc_pkg::job_t head_job,
	output logic             job_pop,
	output logic [7:0]       out_char,
	output logic             last_char,
	output logic             char_valid,
	input  logic             char_ready
);

	b64enc_pkg::job_t job_q;
	logic             busy_q;
	logic [1:0]       idx_q;
	logic             valid_q;
	logic             load;
	logic             finish;

	// While a job is held, a new character enters the output register when it is empty or being taken.
	assign load    = busy_q && (!valid_q || char_ready);
	assign finish  = load && (idx_q == job_q.last_idx);
	assign job_pop = job_ready && (!busy_q || finish);

	assign char_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + 2'd1;
			end

			if (load) begin
				valid_q <= 1'b1;
			end else if (char_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= head_job;
		end
		if (load) begin
			out_char  <= job_q.chars[idx_q];
			last_char <= job_q.last_msg && (idx_q == job_q.last_idx);
		end
	end

endmodule

// ===== design/base64_stream_encoder_top.sv =====
// Streaming Base64 encoder: one byte in per transfer, one to four characters out.
// A byte's first character passes through its queue slot, the back-end job register
// and the output register. Characters leave one per cycle, set by the back-end
// serializer, while char_ready is high: four characters per three bytes sustained;
// bytes are taken every cycle while the job queue has room. Reset clears the group
// phase, the leftover bits, the queue and the output valid flag. Depends on b64enc_pkg.
`timescale 1ns / 1ps

module base64_stream_encoder_top #(
	parameter int QUEUE_DEPTH = b64enc_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	input  logic       data_valid,
	output logic       data_ready,
	output logic [7:0] out_char,
	output logic       last_char,
	output logic       char_valid,
	input  logic       char_ready
);

	b64enc_pkg::job_t new_job;
	b64enc_pkg::job_t head_job;
	logic             take;
	logic             q_not_full;
	logic             q_not_empty;
	logic             q_pop;

	assign data_ready = q_not_full;
	assign take       = data_valid && q_not_full;

	b64enc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.take           (take),
		.job            (new_job)
	);

	b64enc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_job  (new_job),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_job  (head_job)
	);

	b64enc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_ready  (q_not_empty),
		.head_job   (head_job),
		.job_pop    (q_pop),
		.out_char   (out_char),
		.last_char  (last_char),
		.char_valid (char_valid),
		.char_ready (char_ready)
	);

endmodule
